// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the RTL; clock clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PDSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define PDSA_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/pdsa_pkg.sv -----
// ----------------------------------------------------------------------------
// pdsa_pkg
// Shared constants, types and control/status bundles of the slot allocator.
// ----------------------------------------------------------------------------
package pdsa_pkg;

    localparam int SLOTS     = 16;
    localparam int ADDRESSES = 128;

    // fixed field widths
    localparam int ADDR_W     = 7;
    localparam int CONF_W     = 4;
    localparam int SLOT_OUT_W = 4;
    localparam int ACT_OUT_W  = 5;
    localparam int EV_W       = 2;

    // derived widths
    localparam int IDX_W  = (ADDRESSES > 1) ? $clog2(ADDRESSES) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [CONF_W-1:0] CONF_MAX_RESET = CONF_W'(3);

    typedef enum logic [EV_W-1:0] {
        EV_STATUS,
        EV_LOCKED,
        EV_DROPPED,
        EV_RELEASED
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE_RD,
        ST_PROBE_UPD,
        ST_SCAN,
        ST_ALLOC,
        ST_FLUSH
    } state_t;

    // one entry of the per-address store
    typedef struct packed {
        logic [CONF_W-1:0] conf;
        logic              locked;
        logic [SLOT_W-1:0] slot;
    } entry_t;

    // one result without its last flag
    typedef struct packed {
        logic [ADDR_W-1:0]    item_address;
        logic [CONF_W-1:0]    confidence_level;
        logic                 is_locked;
        logic [SLOT_OUT_W-1:0] slot;
        event_t               event_res;
        logic [ACT_OUT_W-1:0] active_count;
    } result_t;

    typedef struct packed {
        logic in_ready;
        logic in_take;
        logic probe_upd;
        logic idx_clear;
        logic idx_inc;
        logic scan_rd;
        logic alloc_lock;
        logic alloc_drop;
        logic out_load;
        logic out_last;
        logic pend_clear;
    } ctrl_t;

    typedef struct packed {
        logic             in_valid;
        logic             eos;
        logic             pend_hit;
        logic             idx_last;
        logic             ent_locked;
        logic             slot_avail;
        logic             out_free;
        logic [SLOTS-1:0] slot_map;
        logic [CNT_W-1:0] active;
    } status_t;

endpackage

// ----- src/pdsa_req_if.sv -----
// ----------------------------------------------------------------------------
// pdsa_req_if
// Probe request channel: valid/ready with address, response and scan end.
// ----------------------------------------------------------------------------
interface pdsa_req_if;

    logic                       valid;
    logic                       ready;
    logic [pdsa_pkg::ADDR_W-1:0] address;
    logic                       responded;
    logic                       end_of_scan;

    modport source (output valid, output address, output responded,
                    output end_of_scan, input ready);
    modport sink   (input valid, input address, input responded,
                    input end_of_scan, output ready);

endinterface

// ----- src/pdsa_res_if.sv -----
// ----------------------------------------------------------------------------
// pdsa_res_if
// Result channel: valid/ready with per-address status and event.
// ----------------------------------------------------------------------------
interface pdsa_res_if;

    logic                           valid;
    logic                           ready;
    logic [pdsa_pkg::ADDR_W-1:0]     item_address;
    logic [pdsa_pkg::CONF_W-1:0]     confidence_level;
    logic                           is_locked;
    logic [pdsa_pkg::SLOT_OUT_W-1:0] slot;
    logic [pdsa_pkg::EV_W-1:0]       event_res;
    logic [pdsa_pkg::ACT_OUT_W-1:0]  active_count;
    logic                           last;

    modport source (output valid, output item_address, output confidence_level,
                    output is_locked, output slot, output event_res,
                    output active_count, output last, input ready);
    modport sink   (input valid, input item_address, input confidence_level,
                    input is_locked, input slot, input event_res,
                    input active_count, input last, output ready);

endinterface

// ----- src/pdsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// pdsa_ctrl
// Sequencer: probe update, end-of-scan walk and result hand-off.
// ----------------------------------------------------------------------------
module pdsa_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  pdsa_pkg::status_t status,
    output pdsa_pkg::ctrl_t   ctrl
);

    pdsa_pkg::state_t state_reg;
    pdsa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pdsa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdsa_pkg::ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    state_next = pdsa_pkg::ST_PROBE_RD;
                end
            end
            pdsa_pkg::ST_PROBE_RD:
            begin
                state_next = pdsa_pkg::ST_PROBE_UPD;
            end
            pdsa_pkg::ST_PROBE_UPD:
            begin
                state_next = status.eos ? pdsa_pkg::ST_SCAN : pdsa_pkg::ST_FLUSH;
            end
            pdsa_pkg::ST_SCAN:
            begin
                if (status.pend_hit)
                begin
                    state_next = pdsa_pkg::ST_ALLOC;
                end
                else if (status.idx_last)
                begin
                    state_next = pdsa_pkg::ST_FLUSH;
                end
            end
            pdsa_pkg::ST_ALLOC:
            begin
                if (status.ent_locked)
                begin
                    state_next = status.idx_last ? pdsa_pkg::ST_FLUSH : pdsa_pkg::ST_SCAN;
                end
                else if (status.out_free)
                begin
                    if (status.slot_avail && !status.idx_last)
                    begin
                        state_next = pdsa_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = pdsa_pkg::ST_FLUSH;
                    end
                end
            end
            pdsa_pkg::ST_FLUSH:
            begin
                if (status.out_free)
                begin
                    state_next = pdsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pdsa_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            pdsa_pkg::ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                ctrl.in_take  = status.in_valid;
            end
            pdsa_pkg::ST_PROBE_UPD:
            begin
                ctrl.probe_upd = 1'b1;
                ctrl.idx_clear = 1'b1;
            end
            pdsa_pkg::ST_SCAN:
            begin
                ctrl.scan_rd = status.pend_hit;
                ctrl.idx_inc = !status.pend_hit && !status.idx_last;
            end
            pdsa_pkg::ST_ALLOC:
            begin
                if (status.ent_locked)
                begin
                    ctrl.idx_inc = !status.idx_last;
                end
                else if (status.out_free)
                begin
                    ctrl.out_load   = 1'b1;
                    ctrl.alloc_lock = status.slot_avail;
                    ctrl.alloc_drop = !status.slot_avail;
                    ctrl.idx_inc    = status.slot_avail && !status.idx_last;
                end
            end
            pdsa_pkg::ST_FLUSH:
            begin
                ctrl.out_load   = status.out_free;
                ctrl.out_last   = 1'b1;
                ctrl.pend_clear = status.out_free && status.eos;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// ----- src/pdsa_datapath.sv -----
// ----------------------------------------------------------------------------
// pdsa_datapath
// Address store, pending list, slot map, result hold and output registers.
// ----------------------------------------------------------------------------
module pdsa_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [pdsa_pkg::CONF_W-1:0]  cfg_wdata,
    pdsa_req_if.sink                     req,
    pdsa_res_if.source                   res,
    input  pdsa_pkg::ctrl_t              ctrl,
    output pdsa_pkg::status_t            status
);

    // configuration
    logic [pdsa_pkg::CONF_W-1:0] cmax_reg;
    logic [pdsa_pkg::CONF_W-1:0] cmax;

    // latched request
    logic [pdsa_pkg::ADDR_W-1:0] addr_reg;
    logic                        resp_reg;
    logic                        eos_reg;
    logic                        inrange_reg;

    // address store: memory plus per-entry valid bits
    pdsa_pkg::entry_t            mem [pdsa_pkg::ADDRESSES];
    logic [pdsa_pkg::ADDRESSES-1:0] ent_valid_reg;
    pdsa_pkg::entry_t            rd_data_reg;
    logic                        rd_ok_reg;
    logic                        rd_en;
    logic [pdsa_pkg::IDX_W-1:0]  rd_idx;
    logic                        wr_en;
    logic [pdsa_pkg::IDX_W-1:0]  wr_idx;
    pdsa_pkg::entry_t            wr_data;
    pdsa_pkg::entry_t            ent;

    // scan state
    logic [pdsa_pkg::ADDR_W-1:0] pend_list_reg [pdsa_pkg::SLOTS];
    logic                        pend_hit;
    logic [pdsa_pkg::CNT_W-1:0]  pcount_reg;
    logic [pdsa_pkg::SLOTS-1:0]  slot_map_reg;
    logic [pdsa_pkg::SLOTS-1:0]  slot_map_next;
    logic [pdsa_pkg::CNT_W-1:0]  active_reg;
    logic [pdsa_pkg::CNT_W-1:0]  active_next;
    logic [pdsa_pkg::IDX_W-1:0]  idx_reg;
    logic [pdsa_pkg::IDX_W-1:0]  addr_idx;

    // results
    pdsa_pkg::result_t           hold_reg;
    pdsa_pkg::result_t           hold_next;
    pdsa_pkg::result_t           out_reg;
    logic                        out_last_reg;
    logic                        out_valid_reg;

    // probe update terms
    logic [pdsa_pkg::CONF_W-1:0] conf_new;
    logic                        enqueue;
    logic                        release_hit;
    pdsa_pkg::entry_t            probe_ent;

    // free slot search
    logic [pdsa_pkg::SLOT_W-1:0] free_slot;

    assign cmax     = (cmax_reg == '0) ? pdsa_pkg::CONF_W'(1) : cmax_reg;
    assign addr_idx = pdsa_pkg::IDX_W'(addr_reg);
    assign ent      = rd_ok_reg ? rd_data_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmax_reg <= pdsa_pkg::CONF_MAX_RESET;
        end
        else if (cfg_we)
        begin
            cmax_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.in_take)
        begin
            addr_reg    <= req.address;
            resp_reg    <= req.responded;
            eos_reg     <= req.end_of_scan;
            inrange_reg <= ({1'b0, req.address} < (pdsa_pkg::ADDR_W + 1)'(pdsa_pkg::ADDRESSES));
        end
    end

    // probe step
    always_comb
    begin
        enqueue     = 1'b0;
        release_hit = 1'b0;
        probe_ent   = ent;
        if (resp_reg)
        begin
            conf_new = (ent.conf < cmax) ? ent.conf + pdsa_pkg::CONF_W'(1) : cmax;
            enqueue  = (conf_new == cmax) && !ent.locked
                       && (pcount_reg < pdsa_pkg::CNT_W'(pdsa_pkg::SLOTS));
        end
        else
        begin
            conf_new    = (ent.conf != '0) ? ent.conf - pdsa_pkg::CONF_W'(1) : '0;
            release_hit = (conf_new == '0) && ent.locked;
        end
        probe_ent.conf = conf_new;
        if (release_hit)
        begin
            probe_ent.locked = 1'b0;
            probe_ent.slot   = '0;
        end
    end

    // lowest free slot
    always_comb
    begin
        free_slot = '0;
        for (int s = pdsa_pkg::SLOTS - 1; s >= 0; s--)
        begin
            if (!slot_map_reg[s])
            begin
                free_slot = pdsa_pkg::SLOT_W'(s);
            end
        end
    end

    // walk index against the live part of the pending list
    always_comb
    begin
        pend_hit = 1'b0;
        for (int i = 0; i < pdsa_pkg::SLOTS; i++)
        begin
            if ((pdsa_pkg::CNT_W'(i) < pcount_reg)
                && (pend_list_reg[i] == pdsa_pkg::ADDR_W'(idx_reg)))
            begin
                pend_hit = 1'b1;
            end
        end
    end

    // store write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = idx_reg;
        wr_data = probe_ent;
        if (ctrl.probe_upd)
        begin
            wr_en  = inrange_reg;
            wr_idx = addr_idx;
        end
        else if (ctrl.alloc_lock)
        begin
            wr_en          = 1'b1;
            wr_data.conf   = ent.conf;
            wr_data.locked = 1'b1;
            wr_data.slot   = free_slot;
        end
    end

    assign rd_en  = ctrl.in_take || ctrl.scan_rd;
    assign rd_idx = ctrl.in_take ? pdsa_pkg::IDX_W'(req.address) : idx_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                ent_valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= ent_valid_reg[rd_idx];
            end
        end
    end

    // slot map and active count
    always_comb
    begin
        slot_map_next = slot_map_reg;
        active_next   = active_reg;
        if (ctrl.probe_upd && inrange_reg && release_hit)
        begin
            if ({1'b0, ent.slot} < (pdsa_pkg::SLOT_W + 1)'(pdsa_pkg::SLOTS))
            begin
                slot_map_next = slot_map_reg & ~(pdsa_pkg::SLOTS'(1) << ent.slot);
            end
            if (active_reg != '0)
            begin
                active_next = active_reg - pdsa_pkg::CNT_W'(1);
            end
        end
        else if (ctrl.alloc_lock)
        begin
            slot_map_next = slot_map_reg | (pdsa_pkg::SLOTS'(1) << free_slot);
            active_next   = active_reg + pdsa_pkg::CNT_W'(1);
        end
    end

    // pending list; entries at or beyond the count are never looked at
    always_ff @(posedge clk)
    begin
        if (ctrl.probe_upd && inrange_reg && enqueue)
        begin
            pend_list_reg[pcount_reg[pdsa_pkg::SLOT_W-1:0]] <= addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_map_reg <= '0;
            active_reg   <= '0;
            pcount_reg   <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            slot_map_reg <= slot_map_next;
            active_reg   <= active_next;
            if (ctrl.pend_clear)
            begin
                pcount_reg <= '0;
            end
            else if (ctrl.probe_upd && inrange_reg && enqueue)
            begin
                pcount_reg <= pcount_reg + pdsa_pkg::CNT_W'(1);
            end
            if (ctrl.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (ctrl.idx_inc)
            begin
                idx_reg <= idx_reg + pdsa_pkg::IDX_W'(1);
            end
        end
    end

    // result staging
    always_comb
    begin
        hold_next = hold_reg;
        if (ctrl.probe_upd)
        begin
            hold_next.item_address     = addr_reg;
            hold_next.confidence_level = inrange_reg ? probe_ent.conf : '0;
            hold_next.is_locked        = inrange_reg && probe_ent.locked;
            hold_next.slot             = (inrange_reg && probe_ent.locked)
                                         ? pdsa_pkg::SLOT_OUT_W'(probe_ent.slot) : '0;
            hold_next.event_res        = (inrange_reg && release_hit)
                                         ? pdsa_pkg::EV_RELEASED : pdsa_pkg::EV_STATUS;
            hold_next.active_count     = pdsa_pkg::ACT_OUT_W'(active_next);
        end
        else if (ctrl.alloc_lock || ctrl.alloc_drop)
        begin
            hold_next.item_address     = pdsa_pkg::ADDR_W'(idx_reg);
            hold_next.confidence_level = ent.conf;
            hold_next.is_locked        = ctrl.alloc_lock;
            hold_next.slot             = ctrl.alloc_lock
                                         ? pdsa_pkg::SLOT_OUT_W'(free_slot) : '0;
            hold_next.event_res        = ctrl.alloc_lock
                                         ? pdsa_pkg::EV_LOCKED : pdsa_pkg::EV_DROPPED;
            hold_next.active_count     = pdsa_pkg::ACT_OUT_W'(active_next);
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        if (ctrl.out_load)
        begin
            out_reg      <= hold_reg;
            out_last_reg <= ctrl.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign req.ready            = ctrl.in_ready;
    assign res.valid            = out_valid_reg;
    assign res.item_address     = out_reg.item_address;
    assign res.confidence_level = out_reg.confidence_level;
    assign res.is_locked        = out_reg.is_locked;
    assign res.slot             = out_reg.slot;
    assign res.event_res        = out_reg.event_res;
    assign res.active_count     = out_reg.active_count;
    assign res.last             = out_last_reg;

    assign status.in_valid   = req.valid;
    assign status.eos        = eos_reg;
    assign status.pend_hit   = pend_hit;
    assign status.idx_last   = (idx_reg == pdsa_pkg::IDX_W'(pdsa_pkg::ADDRESSES - 1));
    assign status.ent_locked = ent.locked;
    assign status.slot_avail = !(&slot_map_reg);
    assign status.out_free   = !out_valid_reg || res.ready;
    assign status.slot_map   = slot_map_reg;
    assign status.active     = active_reg;

endmodule

// ----- src/presence_debounce_slot_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// presence_debounce_slot_allocator_unit
// Debounces bus-probe results per address and hands out slots at scan end.
// ----------------------------------------------------------------------------
// Use:
//   req  - probe requests (address, responded, end_of_scan), valid/ready.
//   res  - results, valid/ready; one or more per request, last marks the
//          final result of a request.
//   cfg_we/cfg_wdata - confidence_max, written only while the block is idle.
// Each request gives first a status (or release) result for the probed
// address. On end_of_scan every address is then checked against the pending
// list, one address a cycle while none is pending; a pending address is read
// from the store and may wait on the receiver. Each newly locked address
// gives a result, and the first one that finds every slot taken gives a drop
// result and ends the walk. One request is handled at a time: a new one is
// taken once the last result of the previous one is loaded, and a scan end
// adds the walk over the whole address range to a request's handling.
// Reset clears the store (valid bits), the slot map, the pending count and
// the counters at once; a request can be taken as soon as reset is released.
// A stalled receiver holds the output register; the walk waits on it while
// one further result is staged in the hold register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module presence_debounce_slot_allocator_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pdsa_pkg::CONF_W-1:0] cfg_wdata,
    pdsa_req_if.sink                    req,
    pdsa_res_if.source                  res
);

    pdsa_pkg::ctrl_t   ctrl;
    pdsa_pkg::status_t status;

    // sequencer
    pdsa_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // store, maps and result registers
    pdsa_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .res       (res),
        .ctrl      (ctrl),
        .status    (status)
    );

    // a result is never loaded over one still waiting
    `PDSA_ASSERT(a_load_free, ctrl.out_load |-> status.out_free, "output overwritten")
    // a taken request closes the input until its results are out
    `PDSA_ASSERT(a_take_close, ctrl.in_take |=> !ctrl.in_ready, "request taken while busy")
    // occupied slots and the active count agree
    `PDSA_ASSERT(a_slot_count, $countones(status.slot_map) == int'(status.active), "slot map and active count disagree")
    // lock and drop are exclusive
    `PDSA_NEVER(a_lock_drop, ctrl.alloc_lock && ctrl.alloc_drop, "lock and drop together")

endmodule

// ----- tb/sv/presence_debounce_slot_allocator_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// presence_debounce_slot_allocator_unit_checker
// Watches the request, result and register ports, keeps its own copy of the
// confidence store and slot map, and compares every result with the oldest
// predicted one. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module presence_debounce_slot_allocator_unit_checker
    import pdsa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CONF_W-1:0] cfg_wdata,
    pdsa_req_if               req,
    pdsa_res_if               res,
    output int                fail_count,
    output int                outstanding
);

    typedef struct packed {
        logic [ADDR_W-1:0]     addr;
        logic [CONF_W-1:0]     conf;
        logic                  locked;
        logic [SLOT_OUT_W-1:0] slot;
        event_t                ev;
        logic [ACT_OUT_W-1:0]  active;
        logic                  last;
    } probe_outcome_t;

    logic [CONF_W-1:0] conf_max;
    logic [CONF_W-1:0] conf_tab   [ADDRESSES];
    logic              locked_tab [ADDRESSES];
    logic [SLOT_W-1:0] slot_tab   [ADDRESSES];
    logic [SLOTS-1:0]  slot_busy;
    logic [ADDR_W-1:0] pend_q [$];
    int                holders;

    probe_outcome_t    outcome_q [$];
    probe_outcome_t    exp_out;

    initial fail_count = 0;

    function automatic probe_outcome_t outcome_for(input logic [ADDR_W-1:0] a,
                                                   input event_t ev);
        probe_outcome_t o;
        o.addr   = a;
        o.conf   = conf_tab[a];
        o.locked = locked_tab[a];
        o.slot   = locked_tab[a] ? SLOT_OUT_W'(slot_tab[a]) : '0;
        o.ev     = ev;
        o.active = ACT_OUT_W'(holders);
        o.last   = 1'b0;
        return o;
    endfunction

    // Debounce one probe, then run the end-of-scan allocation if flagged.
    function automatic void predict_probe(input logic [ADDR_W-1:0] a,
                                          input logic resp, input logic eos);
        probe_outcome_t    step_out [SLOTS+2];
        int                n;
        int                lim;
        int                x;
        int                s;
        int                free_idx;
        bit                hit;
        logic [CONF_W-1:0] c;
        event_t            ev;

        lim = (conf_max == '0) ? 1 : int'(conf_max);
        ev  = EV_STATUS;
        n   = 0;
        c   = conf_tab[a];
        if (resp)
        begin
            c = (int'(c) < lim) ? c + 1'b1 : CONF_W'(lim);
            conf_tab[a] = c;
            if (int'(c) == lim && !locked_tab[a] && pend_q.size() < SLOTS)
                pend_q.push_back(a);
        end
        else
        begin
            if (c != '0)
                c = c - 1'b1;
            conf_tab[a] = c;
            if (c == '0 && locked_tab[a])
            begin
                slot_busy[slot_tab[a]] = 1'b0;
                locked_tab[a] = 1'b0;
                slot_tab[a]   = '0;
                if (holders > 0)
                    holders--;
                ev = EV_RELEASED;
            end
        end
        step_out[n] = outcome_for(a, ev);
        n++;

        if (eos)
        begin
            for (x = 0; x < ADDRESSES; x++)
            begin
                hit = 1'b0;
                foreach (pend_q[i])
                    if (pend_q[i] == ADDR_W'(x))
                        hit = 1'b1;
                if (locked_tab[x] || !hit)
                    continue;
                free_idx = -1;
                for (s = SLOTS - 1; s >= 0; s--)
                    if (!slot_busy[s])
                        free_idx = s;
                if (free_idx < 0)
                begin
                    step_out[n] = outcome_for(ADDR_W'(x), EV_DROPPED);
                    n++;
                    break;
                end
                locked_tab[x] = 1'b1;
                slot_tab[x]   = SLOT_W'(free_idx);
                slot_busy[free_idx] = 1'b1;
                holders++;
                step_out[n] = outcome_for(ADDR_W'(x), EV_LOCKED);
                n++;
            end
            pend_q.delete();
        end

        step_out[n-1].last = 1'b1;
        for (x = 0; x < n; x++)
            outcome_q.push_back(step_out[x]);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_max  = CONF_MAX_RESET;
            slot_busy = '0;
            holders   = 0;
            for (int i = 0; i < ADDRESSES; i++)
            begin
                conf_tab[i]   = '0;
                locked_tab[i] = 1'b0;
                slot_tab[i]   = '0;
            end
            pend_q.delete();
            outcome_q.delete();
        end
        else
        begin
            if (cfg_we)
                conf_max = cfg_wdata;
            if (req.valid && req.ready)
                predict_probe(req.address, req.responded, req.end_of_scan);
            if (res.valid && res.ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: unexpected result: addr %0d event %0d", $time,
                             res.item_address, res.event_res);
                    fail_count++;
                end
                else
                begin
                    exp_out = outcome_q.pop_front();
                    check_field("item_address", 32'(exp_out.addr), 32'(res.item_address));
                    check_field("confidence_level", 32'(exp_out.conf),
                                32'(res.confidence_level));
                    check_field("is_locked", 32'(exp_out.locked), 32'(res.is_locked));
                    check_field("slot", 32'(exp_out.slot), 32'(res.slot));
                    check_field("event_res", 32'(exp_out.ev), 32'(res.event_res));
                    check_field("active_count", 32'(exp_out.active), 32'(res.active_count));
                    check_field("last", 32'(exp_out.last), 32'(res.last));
                end
            end
        end
        outstanding = outcome_q.size();
    end

endmodule

// ----- tb/sv/presence_debounce_slot_allocator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// presence_debounce_slot_allocator_unit_tb
// Drives probe requests and the confidence_max register into the allocator;
// a checker beside the block predicts and compares every result. A short
// directed run is followed by phases of randomised scans over device pools.
// ----------------------------------------------------------------------------
module presence_debounce_slot_allocator_unit_tb;

    import pdsa_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 8;     // after the last result, before a register write
    localparam int DRAIN_CYCLES = 200;   // covers a full end-of-scan walk
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off, fills the block

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CONF_W-1:0] cfg_wdata;

    pdsa_req_if req_if ();
    pdsa_res_if res_if ();

    int fail_count;
    int outstanding;
    int cycles = 0;

    // idling knobs; the two percentages change only just after a rising edge
    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;

    // which devices in a pool currently answer their probe
    bit present [ADDRESSES];
    int pool_a;
    int pool_b;

    presence_debounce_slot_allocator_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .res       (res_if)
    );

    presence_debounce_slot_allocator_unit_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .req         (req_if),
        .res         (res_if),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Receiver: random stalls, plus the long hold-off counted down here.
    always @(negedge clk)
    begin
        if (!rst_n)
            res_if.ready = 1'b0;
        else if (hold_left > 0)
        begin
            res_if.ready = 1'b0;
            hold_left--;
        end
        else
            res_if.ready = ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("presence_debounce_slot_allocator_unit_tb: errors");
            $finish;
        end
    end

    // Offer one probe request; returns at the edge where it is accepted.
    // Valid stays high afterwards so back-to-back requests leave no gap.
    task automatic send_probe(input logic [ADDR_W-1:0] a, input logic resp,
                              input logic eos);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid       = 1'b1;
        req_if.address     = a;
        req_if.responded   = resp;
        req_if.end_of_scan = eos;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait for every predicted result to come back.
    task automatic wait_quiet();
        @(negedge clk);
        req_if.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Register writes only ever happen with the block idle.
    task automatic write_conf_max(input logic [CONF_W-1:0] v);
        wait_quiet();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // Repeated scans over one pool of addresses. Each scan probes the pool in
    // order with end_of_scan on its last request; some requests are replaced
    // by noise, some answers flicker, and now and then a scan is left open.
    // A device joins or leaves the bus between scans.
    task automatic run_scans(input int n_req, input int base, input int pool_size,
                             input int presence_pct, input bit hold_mid);
        int  sent;
        int  k;
        int  a;
        bit  resp;
        bit  eos;
        bit  open_scan;

        for (k = 0; k < pool_size; k++)
            present[base + k] = ($urandom_range(99) < presence_pct);
        sent = 0;
        while (sent < n_req)
        begin
            open_scan = ($urandom_range(9) == 0);
            for (k = 0; k < pool_size && sent < n_req; k++)
            begin
                a    = base + k;
                resp = present[a];
                eos  = (k == pool_size - 1) && !open_scan;
                if ($urandom_range(9) == 0)
                begin
                    a    = $urandom_range(ADDRESSES - 1);
                    resp = $urandom_range(1);
                    eos  = ($urandom_range(3) == 0);
                end
                else if ($urandom_range(19) == 0)
                    resp = !resp;
                send_probe(ADDR_W'(a), resp, eos);
                sent++;
                // receiver holds off while the sender keeps offering requests
                if (hold_mid && sent == n_req / 2)
                    hold_left = HOLD_CYCLES;
            end
            a = base + $urandom_range(pool_size - 1);
            present[a] = !present[a];
        end
    endtask

    task automatic set_idling(input int src_pct, input int sink_pct);
        @(posedge clk);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_if.valid       = 1'b0;
        req_if.address     = '0;
        req_if.responded   = 1'b0;
        req_if.end_of_scan = 1'b0;
        res_if.ready       = 1'b0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        hold_left          = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // ---- directed: reset threshold of three ----
        // lowest address climbs to the threshold and locks into slot 0
        send_probe(7'd0, 1'b1, 1'b0);
        send_probe(7'd0, 1'b1, 1'b0);
        send_probe(7'd0, 1'b1, 1'b1);
        // highest address saturates and is queued more than once in one scan,
        // yet locks only once
        send_probe(7'd127, 1'b1, 1'b0);
        send_probe(7'd127, 1'b1, 1'b0);
        send_probe(7'd127, 1'b1, 1'b0);
        send_probe(7'd127, 1'b1, 1'b1);
        // scan end with nothing queued; counter already at zero stays there
        send_probe(7'd64, 1'b0, 1'b1);
        // three misses bring address 0 down to zero and release its slot
        send_probe(7'd0, 1'b0, 1'b0);
        send_probe(7'd0, 1'b0, 1'b0);
        send_probe(7'd0, 1'b0, 1'b0);

        // ---- directed: threshold of one ----
        write_conf_max(4'd1);
        // queued, then falls back to zero in the same scan: still locked at scan end
        send_probe(7'd9, 1'b1, 1'b0);
        send_probe(7'd9, 1'b0, 1'b0);
        // address 0 takes the freed lowest slot ahead of 9
        send_probe(7'd0, 1'b1, 1'b1);
        send_probe(7'd85, 1'b1, 1'b0);
        send_probe(7'd42, 1'b0, 1'b1);

        pool_a = $urandom_range(ADDRESSES - 20);
        pool_b = $urandom_range(ADDRESSES - 4);

        // ---- random phases ----
        // written zero acts as one: a large pool overfills the pending list
        // and the slot map, so drops appear
        write_conf_max(4'd0);
        set_idling(0, 0);
        run_scans(60, pool_a, 20, 90, 1'b0);

        // top threshold: a small pool climbs towards saturation
        write_conf_max(4'd15);
        set_idling(50, 0);
        run_scans(70, pool_b, 4, 75, 1'b0);

        // threshold lowered under high counters; long receiver hold-off mid-phase
        write_conf_max(4'd2);
        set_idling(0, 50);
        run_scans(60, pool_b, 4, 70, 1'b1);

        // most devices gone from the first pool: releases and re-allocation
        write_conf_max(4'd1);
        set_idling(9, 9);
        run_scans(60, pool_a, 20, 15, 1'b0);

        write_conf_max(CONF_W'($urandom_range(1, 15)));
        set_idling(0, 0);
        run_scans(60, $urandom_range(ADDRESSES - 8), 8, 60, 1'b0);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("presence_debounce_slot_allocator_unit_tb: clean");
        else
            $display("presence_debounce_slot_allocator_unit_tb: errors");
        $finish;
    end

endmodule
